### src/hrcd_pkg.sv
// Package for the HTTP response chunked deframer.
// Holds the phase and token-position codes and the step state struct.
// No dependencies.
package hrcd_pkg;

	typedef enum logic [5:0] {
		PH_HEADER     = 6'b000001,
		PH_CHUNK_SIZE = 6'b000010,
		PH_BODY       = 6'b000100,
		PH_CHUNK_DATA = 6'b001000,
		PH_CHUNK_TAIL = 6'b010000,
		PH_DONE       = 6'b100000
	} phase_t;

	typedef enum logic [5:0] {
		TP_LEAD1 = 6'b000001,
		TP_IN1   = 6'b000010,
		TP_LEAD2 = 6'b000100,
		TP_IN2   = 6'b001000,
		TP_END2  = 6'b010000,
		TP_DEAD  = 6'b100000
	} tokpos_t;

	localparam logic [3:0] KW_HTTP = 4'b0001;
	localparam logic [3:0] KW_CLEN = 4'b0010;
	localparam logic [3:0] KW_TENC = 4'b0100;
	localparam logic [3:0] KW_MARK = 4'b1000;

	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_LF = 8'd10;
	localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
	localparam logic [9:0] STATUS_MAX = 10'd999;
	localparam logic [7:0] REG_MAX_BODY = 8'd0;

	typedef struct packed {
		phase_t       phase;
		tokpos_t      tp;
		logic [3:0]   kw;
		logic [4:0]   idx;
		logic [31:0]  acc;
		logic         line_empty;
		logic         cr_seen;
		logic [31:0]  remaining;
		logic [23:0]  kept;
		logic [9:0]   status;
		logic [31:0]  length;
		logic         chunked;
	} state_t;

	// Parse state after reset: header phase, blank line, nothing counted.
	localparam state_t STATE_RST = '{
		phase: PH_HEADER,
		tp: TP_LEAD1,
		kw: 4'd0,
		idx: 5'd0,
		acc: 32'd0,
		line_empty: 1'b1,
		cr_seen: 1'b0,
		remaining: 32'd0,
		kept: 24'd0,
		status: 10'd0,
		length: 32'd0,
		chunked: 1'b0
	};

	typedef struct packed {
		logic        body_valid;
		logic [7:0]  body_byte;
		logic        done;
		logic        err;
	} flags_t;

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		to_lower = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
	endfunction

	// Keyword character at a position; 0 past the end.
	function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [4:0] i);
		logic [8*18-1:0] s;
		logic [4:0] n;
		s = '0;
		n = 5'd0;
		unique case (k)
			2'd0: begin s = {"http", 112'd0}; n = 5'd4; end
			2'd1: begin s = {"content-length:", 24'd0}; n = 5'd15; end
			2'd2: begin s = "transfer-encoding:"; n = 5'd18; end
			default: begin s = '0; n = 5'd0; end
		endcase
		if (i < n)
			kw_char = s[8*(17 - i) +: 8];
		else
			kw_char = 8'd0;
	endfunction

	function automatic logic [4:0] kw_len(input logic [1:0] k);
		unique case (k)
			2'd0: kw_len = 5'd4;
			2'd1: kw_len = 5'd15;
			2'd2: kw_len = 5'd18;
			default: kw_len = 5'd0;
		endcase
	endfunction

	function automatic logic [7:0] chunk_char(input logic [4:0] i);
		logic [8*7-1:0] s;
		s = "chunked";
		chunk_char = (i < 5'd7) ? s[8*(6 - i[2:0]) +: 8] : 8'd0;
	endfunction

endpackage

### src/hrcd_cfg.sv
// APB-style register block for the deframer: max_body_bytes.
// Depends on hrcd_pkg.
module hrcd_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [23:0] max_body_q
);
	logic sel_max;

	assign sel_max = (paddr == {hrcd_pkg::REG_MAX_BODY[0], 2'b00});
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_body_q <= 24'hFF_FFFF;
		end else if (psel && penable && pwrite && sel_max) begin
			max_body_q <= pwdata[23:0];
		end
	end

	assign prdata = sel_max ? {8'd0, max_body_q} : 32'd0;
endmodule

### src/hrcd_step.sv
// Combinational next-state logic for one response byte of the deframer.
// Depends on hrcd_pkg.
module hrcd_step (
	input  hrcd_pkg::state_t  cur,
	input  logic              new_response,
	input  logic [7:0]        c,
	input  logic [23:0]       max_body,
	output hrcd_pkg::state_t  nxt,
	output hrcd_pkg::flags_t  flg
);
	hrcd_pkg::state_t s;
	hrcd_pkg::state_t f;
	logic [31:0] size;

	// Feed one character to the header or size-line parser.
	function automatic hrcd_pkg::state_t feed(input hrcd_pkg::state_t si,
		input logic [7:0] ch);
		hrcd_pkg::state_t so;
		logic blank, stop, space, hexok;
		logic [4:0] h;
		logic [7:0] lc;
		logic [3:0] d;
		logic [35:0] prod;
		so = si;
		lc = hrcd_pkg::to_lower(ch);
		blank = (ch == 8'h20) || (ch == 8'h09);
		stop = (ch == hrcd_pkg::CH_LF) || (ch == 8'h00);
		space = (ch == 8'h20) || (ch >= 8'd9 && ch <= 8'd13);
		d = ch[3:0];
		if (ch >= 8'h30 && ch <= 8'h39)
			h = {1'b0, ch[3:0]};
		else if (lc >= 8'h61 && lc <= 8'h66)
			h = 5'(lc - 8'h61 + 8'd10);
		else
			h = 5'd16;
		hexok = !h[4];
		prod = 36'd0;
		if (si.phase == hrcd_pkg::PH_HEADER) begin
			so.line_empty = 1'b0;
			unique case (si.tp)
				hrcd_pkg::TP_LEAD1: begin
					if (stop) so.tp = hrcd_pkg::TP_DEAD;
					else if (!blank) begin
						so.kw = hrcd_pkg::KW_HTTP | hrcd_pkg::KW_CLEN | hrcd_pkg::KW_TENC;
						for (int k = 0; k < 3; k++)
							if (lc != hrcd_pkg::kw_char(2'(k), 5'd0))
								so.kw[k] = 1'b0;
						so.idx = 5'd1;
						so.tp = hrcd_pkg::TP_IN1;
					end
				end
				hrcd_pkg::TP_IN1: begin
					if (ch == 8'h20) begin
						priority if (si.kw[0] && si.idx >= hrcd_pkg::kw_len(2'd0))
							so.kw = hrcd_pkg::KW_HTTP;
						else if (si.kw[1] && si.idx >= hrcd_pkg::kw_len(2'd1))
							so.kw = hrcd_pkg::KW_CLEN;
						else if (si.kw[2] && si.idx >= hrcd_pkg::kw_len(2'd2))
							so.kw = hrcd_pkg::KW_TENC;
						else
							so.kw = 4'd0;
						so.tp = hrcd_pkg::TP_LEAD2;
					end else if (stop) begin
						so.tp = hrcd_pkg::TP_DEAD;
					end else begin
						for (int k = 0; k < 3; k++)
							if (si.kw[k] && si.idx < hrcd_pkg::kw_len(2'(k)) &&
								lc != hrcd_pkg::kw_char(2'(k), si.idx))
								so.kw[k] = 1'b0;
						if (si.idx != 5'd31) so.idx = si.idx + 5'd1;
					end
				end
				hrcd_pkg::TP_LEAD2, hrcd_pkg::TP_IN2: begin
					if (si.tp == hrcd_pkg::TP_LEAD2 && stop) so.tp = hrcd_pkg::TP_DEAD;
					else if (si.tp == hrcd_pkg::TP_IN2 && (ch == 8'h20 || stop))
						so.tp = hrcd_pkg::TP_END2;
					else if (si.tp == hrcd_pkg::TP_IN2 || !blank) begin
						if (si.tp == hrcd_pkg::TP_LEAD2) begin
							so.kw = si.kw | hrcd_pkg::KW_MARK;
							so.idx = 5'd0;
							so.acc = 32'd0;
							so.tp = hrcd_pkg::TP_IN2;
						end
						if (so.kw[0] || so.kw[1]) begin
							if (so.kw[3]) begin
								if (so.idx == 5'd0 && ch == 8'h2B) begin
								end else if (ch >= 8'h30 && ch <= 8'h39) begin
									prod = {1'b0, so.acc, 3'd0} + {3'd0, so.acc, 1'b0} +
										36'(d);
									so.acc = (prod[35:32] != 4'd0) ? hrcd_pkg::SAT32 : prod[31:0];
								end else begin
									so.kw[3] = 1'b0;
								end
							end
						end else if (so.kw[2]) begin
							if (so.idx < 5'd7 && lc != hrcd_pkg::chunk_char(so.idx))
								so.kw[3] = 1'b0;
						end
						if (so.idx != 5'd31) so.idx = so.idx + 5'd1;
					end
				end
				default: ;
			endcase
		end else begin
			if (si.tp == hrcd_pkg::TP_LEAD1 || si.tp == hrcd_pkg::TP_IN1) begin
				if (si.tp == hrcd_pkg::TP_LEAD1 && space) begin
				end else if (si.tp == hrcd_pkg::TP_LEAD1 && ch == 8'h2B) begin
					so.tp = hrcd_pkg::TP_IN1;
				end else if (si.tp == hrcd_pkg::TP_LEAD1 && (ch == 8'h2D || !hexok)) begin
					so.tp = hrcd_pkg::TP_DEAD;
				end else begin
					so.tp = hrcd_pkg::TP_IN1;
					if (hexok) begin
						so.acc = (si.acc[31:28] != 4'd0) ? hrcd_pkg::SAT32
							: {si.acc[27:0], h[3:0]};
						if (si.idx != 5'd31) so.idx = si.idx + 5'd1;
					end else if ((ch == 8'h78 || ch == 8'h58) && si.idx == 5'd1 &&
						si.acc == 32'd0) begin
						so.idx = 5'd2;
					end else begin
						so.tp = hrcd_pkg::TP_DEAD;
					end
				end
			end
		end
		return so;
	endfunction

	function automatic hrcd_pkg::state_t start_line(input hrcd_pkg::state_t si);
		hrcd_pkg::state_t so;
		so = si;
		so.tp = hrcd_pkg::TP_LEAD1;
		so.kw = 4'd0;
		so.idx = 5'd0;
		so.acc = 32'd0;
		so.line_empty = 1'b1;
		so.cr_seen = 1'b0;
		return so;
	endfunction

	always_comb begin
		s = cur;
		if (new_response) begin
			s = start_line(cur);
			s.phase = hrcd_pkg::PH_HEADER;
			s.remaining = 32'd0;
			s.kept = 24'd0;
			s.status = 10'd0;
			s.length = 32'd0;
			s.chunked = 1'b0;
		end
		f = s;
		flg = '0;
		size = s.acc;
		unique case (s.phase)
			hrcd_pkg::PH_HEADER, hrcd_pkg::PH_CHUNK_SIZE: begin
				if (s.cr_seen && c == hrcd_pkg::CH_LF) begin
					if (s.phase == hrcd_pkg::PH_HEADER) begin
						f = start_line(s);
						if (s.line_empty) begin
							if (s.chunked) f.phase = hrcd_pkg::PH_CHUNK_SIZE;
							else begin
								f.remaining = s.length;
								if (s.length == 32'd0) begin
									f.phase = hrcd_pkg::PH_DONE;
									flg.done = 1'b1;
								end else f.phase = hrcd_pkg::PH_BODY;
							end
						end else if (s.tp == hrcd_pkg::TP_IN2 || s.tp == hrcd_pkg::TP_END2) begin
							if (s.kw[0])
								f.status = (s.acc > 32'(hrcd_pkg::STATUS_MAX))
									? hrcd_pkg::STATUS_MAX : s.acc[9:0];
							else if (s.kw[1])
								f.length = s.acc;
							else if (s.kw[2] && s.kw[3] && s.idx >= 5'd7)
								f.chunked = 1'b1;
						end
					end else begin
						f = start_line(s);
						if (size == 32'd0) begin
							f.chunked = 1'b0;
							f.phase = hrcd_pkg::PH_DONE;
							flg.done = 1'b1;
						end else begin
							f.length = (s.length > hrcd_pkg::SAT32 - size)
								? hrcd_pkg::SAT32 : s.length + size;
							f.remaining = size;
							f.phase = hrcd_pkg::PH_CHUNK_DATA;
						end
					end
				end else begin
					if (s.cr_seen) f = feed(f, hrcd_pkg::CH_CR);
					if (c == hrcd_pkg::CH_CR) f.cr_seen = 1'b1;
					else begin
						f.cr_seen = 1'b0;
						f = feed(f, c);
					end
				end
			end
			hrcd_pkg::PH_BODY, hrcd_pkg::PH_CHUNK_DATA: begin
				if (s.kept < max_body) begin
					flg.body_valid = 1'b1;
					flg.body_byte = c;
					f.kept = s.kept + 24'd1;
				end
				if (s.remaining > 32'd1 ) f.remaining = s.remaining - 32'd1;
				else begin
					f.remaining = 32'd0;
					if (s.phase == hrcd_pkg::PH_BODY) begin
						f.phase = hrcd_pkg::PH_DONE;
						flg.done = 1'b1;
					end else begin
						f.phase = hrcd_pkg::PH_CHUNK_TAIL;
						f.idx = 5'd0;
					end
				end
			end
			hrcd_pkg::PH_CHUNK_TAIL: begin
				if (s.idx != 5'd31) f.idx = s.idx + 5'd1;
				if (s.idx + 5'd1 >= 5'd2) begin
					f = start_line(f);
					f.phase = hrcd_pkg::PH_CHUNK_SIZE;
				end
			end
			default: flg.err = 1'b1;
		endcase
		nxt = f;
	end
endmodule

### src/http_response_chunked_deframer.sv
// Top level of the HTTP response chunked deframer.
// Depends on hrcd_pkg, hrcd_cfg and hrcd_step.
//
// Usage:
//  - Input channel (in_valid/in_ready): one beat carries one response byte
//    (data_byte) and new_response, which restarts parsing before the byte.
//  - Output channel (out_valid/out_ready): one beat per input beat, with the
//    kept body byte (body_valid, body_byte), status_code, total_length,
//    chunked_mode, done_res and parse_error as seen after that byte.
//  - APB-style port: register 0 at address 0 is max_body_bytes (24 bits).
//    Write it only while no beat is in flight.
// Timing: one byte per cycle sustained while the receiver keeps out_ready high.
// An input beat is parsed in the cycle it is accepted and its result is
// registered, into the output register or, while that is held, the skid slot.
// A one-entry skid behind the result register lets the input take one more
// beat after the receiver stalls; then in_ready drops.
// Reset: parse state returns to the header phase, max_body_bytes goes to
// all ones, and no result is held.
module http_response_chunked_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        new_response,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        body_valid,
	output logic [7:0]  body_byte,
	output logic [9:0]  status_code,
	output logic [31:0] total_length,
	output logic        chunked_mode,
	output logic        done_res,
	output logic        parse_error,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	typedef struct packed {
		logic        body_valid;
		logic [7:0]  body_byte;
		logic [9:0]  status;
		logic [31:0] length;
		logic        chunked;
		logic        done;
		logic        err;
	} result_t;

	logic [23:0]      max_body;
	hrcd_pkg::state_t st_q;
	hrcd_pkg::state_t st_next;
	hrcd_pkg::flags_t flg;
	result_t          res_now;
	result_t          out_s1;
	result_t          skid_q;
	logic             out_vld_s1;
	logic             skid_vld_q;
	logic             in_fire;

	hrcd_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready), .max_body_q(max_body)
	);

	hrcd_step u_step (
		.cur(st_q), .new_response(new_response), .c(data_byte),
		.max_body(max_body), .nxt(st_next), .flg(flg)
	);

	// Accept while the skid slot is free; it absorbs the beat taken in the
	// cycle the receiver stalls.
	assign in_ready = !skid_vld_q;
	assign in_fire = in_valid && in_ready;

	always_comb begin
		res_now.body_valid = flg.body_valid;
		res_now.body_byte = flg.body_byte;
		res_now.status = st_next.status;
		res_now.length = st_next.length;
		res_now.chunked = st_next.chunked;
		res_now.done = flg.done;
		res_now.err = flg.err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= hrcd_pkg::STATE_RST;
		end else if (in_fire) begin
			st_q <= st_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_s1 <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (!out_vld_s1 || out_ready) begin
				// Output slot drains: refill from skid first, else from input.
				if (skid_vld_q) begin
					out_vld_s1 <= 1'b1;
					skid_vld_q <= in_fire;
				end else begin
					out_vld_s1 <= in_fire;
				end
			end else if (in_fire) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_s1 || out_ready) begin
			if (skid_vld_q) begin
				out_s1 <= skid_q;
				if (in_fire) skid_q <= res_now;
			end else if (in_fire) begin
				out_s1 <= res_now;
			end
		end else if (in_fire) begin
			skid_q <= res_now;
		end
	end

	assign out_valid = out_vld_s1;
	assign body_valid = out_s1.body_valid;
	assign body_byte = out_s1.body_byte;
	assign status_code = out_s1.status;
	assign total_length = out_s1.length;
	assign chunked_mode = out_s1.chunked;
	assign done_res = out_s1.done;
	assign parse_error = out_s1.err;

`ifndef SYNTHESIS
	a_skid_only_when_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_s1) else $error("skid full with empty output");
	a_no_status_over: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.status <= hrcd_pkg::STATUS_MAX) else $error("status above 999");
	a_err_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && flg.err) |-> (st_q.phase == hrcd_pkg::PH_DONE && !new_response))
		else $error("error outside done phase");
	a_body_no_valid_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && flg.body_valid) |-> !flg.err) else $error("body and error");
`endif
endmodule

### dv/tb_http_response_chunked_deframer.sv
// Testbench for http_response_chunked_deframer: drives response bytes over the
// input channel, predicts every result beat and checks the whole beat.
// Depends on hrcd_pkg (register index, keyword and character codes) and the deframer RTL.
module tb_http_response_chunked_deframer;

	// Predictor phases and token positions, local to the model of the block.
	typedef enum int {M_HEADER, M_SIZE, M_BODY, M_CDATA, M_CTAIL, M_DONE} mphase_e;
	typedef enum int {T_LEAD1, T_IN1, T_LEAD2, T_IN2, T_END2, T_DEAD} mtok_e;

	typedef struct packed {
		logic        body_valid;
		logic [7:0]  body_byte;
		logic [9:0]  status_code;
		logic [31:0] total_length;
		logic        chunked_mode;
		logic        done_res;
		logic        parse_error;
	} beat_t;

	typedef struct packed {
		logic       nr;
		logic [7:0] b;
		logic       chk;   // a typed-in expectation follows
		beat_t      want;
	} row_t;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_ready, new_response = 0;
	logic [7:0] data_byte = 0;
	logic out_valid, out_ready = 0;
	logic body_valid, chunked_mode, done_res, parse_error;
	logic [7:0] body_byte;
	logic [9:0] status_code;
	logic [31:0] total_length;
	logic psel = 0, penable = 0, pwrite = 0, pready;
	logic [2:0] paddr = 0;
	logic [31:0] pwdata = 0, prdata;

	http_response_chunked_deframer dut (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	initial begin
		#20000000;
		$display("FAIL http_response_chunked_deframer");
		$finish;
	end

	// Predictor state
	logic [23:0] body_limit;
	mphase_e     ph;
	mtok_e       tp;
	logic [3:0]  kw;
	int unsigned cidx;
	logic [31:0] acc, remain, len_r;
	logic [23:0] kept;
	logic [9:0]  stat;
	logic        lempty, crs, chk_f;

	beat_t expected_beats[$];
	int    errors = 0;

	function automatic logic [7:0] lc(logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic int hexv(logic [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		c = lc(c);
		if (c >= "a" && c <= "f") return c - "a" + 10;
		return 16;
	endfunction

	function automatic logic [7:0] keyword_char(int k, int i);
		string s;
		s = (k == 0) ? "http" : (k == 1) ? "content-length:" : "transfer-encoding:";
		return (i < s.len()) ? s[i] : 8'd0;
	endfunction

	function automatic int keyword_len(int k);
		return (k == 0) ? 4 : (k == 1) ? 15 : 18;
	endfunction

	function automatic void line_restart();
		tp = T_LEAD1; kw = 0; cidx = 0; acc = 0; lempty = 1; crs = 0;
	endfunction

	function automatic void parse_clear();
		ph = M_HEADER; line_restart();
		remain = 0; kept = 0; stat = 0; len_r = 0; chk_f = 0;
	endfunction

	function automatic void bump();
		if (cidx < 31) cidx++;
	endfunction

	function automatic void tok1_char(logic [7:0] c);
		for (int k = 0; k < 3; k++)
			if (kw[k] && cidx < keyword_len(k) && lc(c) != keyword_char(k, cidx))
				kw[k] = 0;
		bump();
	endfunction

	function automatic void tok2_char(logic [7:0] c);
		string ck;
		logic [31:0] d;
		ck = "chunked";
		if (kw & (hrcd_pkg::KW_HTTP | hrcd_pkg::KW_CLEN)) begin
			if (kw & hrcd_pkg::KW_MARK) begin
				if (cidx == 0 && c == "+") begin
				end else if (c >= "0" && c <= "9") begin
					d = c - "0";
					acc = (acc > (hrcd_pkg::SAT32 - d) / 10) ? hrcd_pkg::SAT32 : acc * 10 + d;
				end else
					kw &= ~hrcd_pkg::KW_MARK;
			end
		end else if (kw & hrcd_pkg::KW_TENC) begin
			if (cidx < 7 && lc(c) != ck[cidx]) kw &= ~hrcd_pkg::KW_MARK;
		end
		bump();
	endfunction

	function automatic void header_char(logic [7:0] c);
		logic blank, stop;
		logic [3:0] found;
		blank = (c == " " || c == 8'd9);
		stop = (c == hrcd_pkg::CH_LF || c == 0);
		lempty = 0;
		case (tp)
			T_LEAD1: if (stop) tp = T_DEAD;
				else if (!blank) begin
					kw = hrcd_pkg::KW_HTTP | hrcd_pkg::KW_CLEN | hrcd_pkg::KW_TENC;
					cidx = 0;
					tok1_char(c); tp = T_IN1;
				end
			T_IN1: if (c == " ") begin
					found = 0;
					for (int k = 0; k < 3 && found == 0; k++)
						if (kw[k] && cidx >= keyword_len(k)) found = 4'(1 << k);
					kw = found; tp = T_LEAD2;
				end else if (stop) tp = T_DEAD;
				else tok1_char(c);
			T_LEAD2: if (stop) tp = T_DEAD;
				else if (!blank) begin
					kw |= hrcd_pkg::KW_MARK; cidx = 0; acc = 0;
					tok2_char(c); tp = T_IN2;
				end
			T_IN2: if (c == " " || stop) tp = T_END2;
				else tok2_char(c);
			default: ;
		endcase
	endfunction

	function automatic void size_char(logic [7:0] c);
		int h;
		h = hexv(c);
		if (tp == T_LEAD1) begin
			if (c == " " || (c >= 9 && c <= 13)) return;
			if (c == "+") begin tp = T_IN1; return; end
			if (c == "-" || h > 15) begin tp = T_DEAD; return; end
			tp = T_IN1;
		end else if (tp != T_IN1)
			return;
		if (h <= 15) begin
			acc = (acc > (hrcd_pkg::SAT32 - h) / 16) ? hrcd_pkg::SAT32 : acc * 16 + h;
			bump();
		end else if ((c == "x" || c == "X") && cidx == 1 && acc == 0)
			cidx = 2;
		else
			tp = T_DEAD;
	endfunction

	function automatic void feed_char(logic [7:0] c);
		if (ph == M_HEADER) header_char(c);
		else size_char(c);
	endfunction

	// Advance the deframer model by one byte and return the result beat.
	function automatic beat_t deframe_byte(logic nr, logic [7:0] c);
		beat_t r;
		logic [31:0] sz;
		r = '0;
		if (nr) parse_clear();
		case (ph)
			M_HEADER, M_SIZE:
				if (crs && c == hrcd_pkg::CH_LF) begin
					if (ph == M_HEADER) begin
						if (lempty) begin
							if (chk_f) ph = M_SIZE;
							else begin
								remain = len_r;
								if (remain == 0) begin ph = M_DONE; r.done_res = 1; end
								else ph = M_BODY;
							end
						end else if (tp == T_IN2 || tp == T_END2) begin
							if (kw & hrcd_pkg::KW_HTTP) stat = (acc > 999) ? 10'd999 : acc[9:0];
							else if (kw & hrcd_pkg::KW_CLEN) len_r = acc;
							else if ((kw & hrcd_pkg::KW_TENC) && (kw & hrcd_pkg::KW_MARK) &&
								cidx >= 7)
								chk_f = 1;
						end
						line_restart();
					end else begin
						sz = acc;
						line_restart();
						if (sz == 0) begin
							chk_f = 0; ph = M_DONE; r.done_res = 1;
						end else begin
							len_r = (len_r > hrcd_pkg::SAT32 - sz) ? hrcd_pkg::SAT32 : len_r + sz;
							remain = sz; ph = M_CDATA;
						end
					end
				end else begin
					if (crs) feed_char(hrcd_pkg::CH_CR);
					if (c == hrcd_pkg::CH_CR) crs = 1;
					else begin crs = 0; feed_char(c); end
				end
			M_BODY, M_CDATA: begin
				if (kept < body_limit) begin
					r.body_valid = 1; r.body_byte = c; kept++;
				end
				if (remain > 0) remain--;
				if (remain == 0) begin
					if (ph == M_BODY) begin ph = M_DONE; r.done_res = 1; end
					else begin ph = M_CTAIL; cidx = 0; end
				end
			end
			M_CTAIL: begin
				bump();
				if (cidx >= 2) begin ph = M_SIZE; line_restart(); end
			end
			default: r.parse_error = 1;
		endcase
		r.status_code = stat;
		r.total_length = len_r;
		r.chunked_mode = chk_f;
		return r;
	endfunction

	// Result side: random stall per beat, compare against the oldest expectation.
	initial begin
		beat_t got, exp_b;
		int gap_n;
		@(posedge arst_n);
		forever begin
			gap_n = $urandom_range(0, 3);
			repeat (gap_n) begin
				@(negedge clk);
				out_ready <= 0;
			end
			@(negedge clk);
			out_ready <= 1;
			do @(posedge clk); while (!out_valid);
			got = '{body_valid, body_byte, status_code, total_length,
				chunked_mode, done_res, parse_error};
			if (expected_beats.size() == 0) begin
				$display("%0t: result with none expected: %p", $time, got);
				errors++;
			end else begin
				exp_b = expected_beats.pop_front();
				if (got !== exp_b) begin
					$display("%0t: mismatch expected %p actual %p", $time, exp_b, got);
					errors++;
				end
			end
		end
	end

	// Send one byte; hold valid and payload until accepted, given gap first.
	task automatic send_byte(logic nr, logic [7:0] c, int gap);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 0;
		end
		@(negedge clk);
		in_valid <= 1; new_response <= nr; data_byte <= c;
		expected_beats.push_back(deframe_byte(nr, c));
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic put(logic nr, logic [7:0] c);
		send_byte(nr, c, $urandom_range(0, 3));
	endtask

	task automatic put_str(string s);
		for (int i = 0; i < s.len(); i++) put(0, s[i]);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(logic [23:0] v);
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= 3'(hrcd_pkg::REG_MAX_BODY) << 2; pwdata <= {8'd0, v};
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		body_limit = v;
	endtask

	// Build one random response: header lines, then plain or chunked body.
	task automatic random_response();
		int chunked, n, clen;
		string s;
		chunked = $urandom_range(0, 1);
		put(1, $urandom_range(0, 1) ? "H" : " ");
		put_str($sformatf("TTP/1.1 %0d OK\r\n", $urandom_range(100, 1200)));
		if ($urandom_range(0, 3) == 0) put_str("X-Junk: a\rb\n\r\n" );
		if (chunked) begin
			put_str($urandom_range(0, 1) ? "Transfer-Encoding: chunked\r\n"
				: "transfer-ENCODING: CHUNKED\r\n");
			put_str("\r\n");
			n = $urandom_range(1, 3);
			for (int k = 0; k < n; k++) begin
				clen = $urandom_range(1, 12);
				s = $urandom_range(0, 1) ? $sformatf("%0h;ext\r\n", clen)
					: $sformatf("0x%0H\r\n", clen);
				put_str(s);
				for (int i = 0; i < clen; i++) put(0, 8'($urandom_range(0, 255)));
				put(1'($urandom()), 8'($urandom_range(0, 255)));
				put(0, 8'($urandom_range(0, 255)));
			end
			put_str($urandom_range(0, 1) ? "0\r\n" : "+00\r\n");
		end else begin
			clen = $urandom_range(0, 14);
			put_str($sformatf("Content-Length: +%0d\r\n\r\n", clen));
			for (int i = 0; i < clen; i++) put(0, 8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 3) == 0) put(0, 8'($urandom_range(0, 255)));
	endtask

	// Directed table; chk marks rows whose result is typed in.
	row_t dir_rows[$];

	initial begin
		body_limit = 24'hFFFFFF;
		parse_clear();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Empty header line with no length ends at once; next byte is late.
		dir_rows.push_back('{1, hrcd_pkg::CH_CR, 1, beat_t'('0)});
		dir_rows.push_back('{0, hrcd_pkg::CH_LF, 1, beat_t'{0, 0, 0, 0, 0, 1, 0}});
		dir_rows.push_back('{0, 8'hFF, 1, beat_t'{0, 0, 0, 0, 0, 0, 1}});
		dir_rows.push_back('{0, 8'h00, 1, beat_t'{0, 0, 0, 0, 0, 0, 1}});
		foreach (dir_rows[i]) begin
			send_byte(dir_rows[i].nr, dir_rows[i].b, 0);
			if (dir_rows[i].chk && expected_beats[$] !== dir_rows[i].want) begin
				$display("%0t: table row %0d expected %p predicted %p", $time, i,
					dir_rows[i].want, expected_beats[$]);
				errors++;
			end
		end
		// Saturating status, huge length, lone LF, NUL, minus sign, single token.
		put(1, "h");
		put_str("ttp/1.0 99999 x\r\n\n\r\nContent-Length: -5\r\n");
		put_str("a");
		put(0, 8'h00);
		put_str("b c\r\nsolo\r\nContent-Length: 99999999999\r\n");
		put_str("Content-Length: 3\r\n\r\n");
		put(0, 8'h00); put(0, 8'hFF); put(0, 8'h80);
		drain();

		// Zero body limit, chunk sizes with saturation and no digits.
		write_limit(24'd0);
		put(1, "H");
		put_str("TTP 200\r\nTransfer-Encoding: chunked\r\n\r\n");
		put_str(" \t+0x2\r\nab\r\nFFFFFFFFF\r\nz");
		put(1, "H");
		put_str("TTP 200\r\ntransfer-encoding: chunk\r\n\r\n");
		put(1, "H");
		put_str("TTP 204\r\nTransfer-Encoding: chunked\r\n\r\n-1\r\n");
		drain();

		// Random responses across several body limits, with a sender pause.
		for (int pass = 0; pass < 4; pass++) begin
			write_limit(pass == 0 ? 24'hFFFFFF : pass == 1 ? 24'd1 :
				pass == 2 ? 24'($urandom_range(0, 20)) : 24'hFFFFFE);
			for (int r = 0; r < 2; r++) begin
				random_response();
				if (r == 0) drain();
			end
			for (int i = 0; i < 20; i++)
				put($urandom_range(0, 9) == 0, 8'($urandom()));
			drain();
		end

		drain();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("PASS http_response_chunked_deframer");
		else
			$display("FAIL http_response_chunked_deframer");
		$finish;
	end
endmodule

### files.f
src/hrcd_pkg.sv
src/hrcd_cfg.sv
src/hrcd_step.sv
src/http_response_chunked_deframer.sv
dv/tb_http_response_chunked_deframer.sv
